FILE: rtl/dip_pkg.sv
`timescale 1ns / 1ps
package dip_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;
   localparam int CLIENT_LIMIT_DEFAULT  = 128;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [15:0] ETH_IPV4        = 16'h0800;
   localparam logic [15:0] ETH_IPV6        = 16'h86DD;
   localparam logic [15:0] ETH_ARP         = 16'h0806;
   localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;

   localparam logic [2:0] ST_FORWARD  = 3'd0;
   localparam logic [2:0] ST_NON_IP   = 3'd1;
   localparam logic [2:0] ST_BAD_ARP  = 3'd2;
   localparam logic [2:0] ST_NO_MATCH = 3'd3;
   localparam logic [2:0] ST_INSERTED = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef struct packed {
      logic        func;
      logic [15:0] frame_type;
      logic [31:0] ipv4_dest;
      logic [15:0] arp_hw_type;
      logic [15:0] arp_proto_type;
      logic [31:0] arp_target;
      logic [63:0] ipv6_dest_high;
      logic [63:0] ipv6_dest_low;
      logic        key_is_v6;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [6:0]  entry_client;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] client;
   } rsp_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic        is_insert;
      logic        drop;
      logic [2:0]  drop_status;
      logic        family;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [6:0]  owner;
   } work_type;

endpackage

FILE: rtl/dip_front.sv
`timescale 1ns / 1ps
module dip_front
   import dip_pkg::*;
(
   input  req_type  req,
   output work_type work
);

   always_comb begin
      work             = '0;
      work.is_insert   = req.func;
      work.drop_status = ST_NO_MATCH;
      if (req.func) begin
         work.family   = req.key_is_v6;
         work.key_high = req.key_is_v6 ? req.key_high : 64'd0;
         work.key_low  = req.key_is_v6 ? req.key_low : {32'd0, req.key_low[31:0]};
         work.owner    = req.entry_client;
      end else if (req.frame_type == ETH_IPV4) begin
         work.key_low = {32'd0, req.ipv4_dest};
      end else if (req.frame_type == ETH_IPV6) begin
         work.family   = 1'b1;
         work.key_high = req.ipv6_dest_high;
         work.key_low  = req.ipv6_dest_low;
      end else if (req.frame_type == ETH_ARP) begin
         if (req.arp_hw_type == ARP_HW_ETHERNET && req.arp_proto_type == ETH_IPV4) begin
            work.key_low = {32'd0, req.arp_target};
         end else begin
            work.drop        = 1'b1;
            work.drop_status = ST_BAD_ARP;
         end
      end else begin
         work.drop        = 1'b1;
         work.drop_status = ST_NON_IP;
      end
   end

endmodule

FILE: rtl/dip_fifo.sv
`timescale 1ns / 1ps
module dip_fifo
   import dip_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output work_type pop_data,
   output logic     empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   work_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/dip_back.sv
`timescale 1ns / 1ps
module dip_back
   import dip_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int CLIENT_LIMIT  = CLIENT_LIMIT_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
   localparam logic [10:0]   LIMIT = 11'(CLIENT_LIMIT);

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;

   typedef struct packed {
      logic        valid;
      logic        family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [6:0]  owner;
   } entry_type;

   entry_type table_mem [TABLE_ENTRIES];

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] sweep_ff, sweep_in;
   logic [IW-1:0] probe_ff, probe_in;
   logic [IW-1:0] tried_ff, tried_in;
   work_type      item_ff, item_in;
   entry_type     rdata_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic          out_free, hit;
   logic [IW-1:0] home;

   function automatic logic [IW-1:0] fold(input logic [128:0] key);
      logic [IW-1:0] h;
      logic [IW:0]   w;
      h = '0;
      for (int i = 0; i < 129; i++) begin
         h[i % IW] = h[i % IW] ^ key[i];
      end
      // bring the folded value below the table size
      w = {1'b0, h};
      if (w >= (IW+1)'(TABLE_ENTRIES)) begin
         w = w - (IW+1)'(TABLE_ENTRIES);
      end
      return w[IW-1:0];
   endfunction

   assign home      = fold({q_data.family, q_data.key_high, q_data.key_low});
   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign hit       = rdata_ff.valid && rdata_ff.family == item_ff.family &&
                      rdata_ff.addr_high == item_ff.key_high &&
                      rdata_ff.addr_low == item_ff.key_low;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      probe_in     = probe_ff;
      tried_in     = tried_ff;
      item_in      = item_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = probe_ff;
      wr_data      = '0;
      unique case (state_ff)
         S_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = sweep_ff + IW'(1);
            if (sweep_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop    = 1'b1;
               item_in  = q_data;
               probe_in = home;
               tried_in = '0;
               if (q_data.drop) begin
                  out_valid_in  = 1'b1;
                  out_in.status = q_data.drop_status;
                  out_in.client = '0;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            out_in.client = '0;
            if (hit) begin
               state_in     = S_IDLE;
               out_valid_in = 1'b1;
               if (item_ff.is_insert) begin
                  wr_en         = 1'b1;
                  wr_data       = rdata_ff;
                  wr_data.owner = item_ff.owner;
                  out_in.status = ST_INSERTED;
               end else if ({4'd0, rdata_ff.owner} < LIMIT) begin
                  out_in.status = ST_FORWARD;
                  out_in.client = rdata_ff.owner;
               end else begin
                  out_in.status = ST_NO_MATCH;
               end
            end else if (!rdata_ff.valid) begin
               // open slot ends the chain: the key is absent
               state_in     = S_IDLE;
               out_valid_in = 1'b1;
               if (item_ff.is_insert) begin
                  wr_en             = 1'b1;
                  wr_data.valid     = 1'b1;
                  wr_data.family    = item_ff.family;
                  wr_data.addr_high = item_ff.key_high;
                  wr_data.addr_low  = item_ff.key_low;
                  wr_data.owner     = item_ff.owner;
                  out_in.status     = ST_INSERTED;
               end else begin
                  out_in.status = ST_NO_MATCH;
               end
            end else if (tried_ff == LAST) begin
               state_in      = S_IDLE;
               out_valid_in  = 1'b1;
               out_in.status = item_ff.is_insert ? ST_FULL : ST_NO_MATCH;
            end else begin
               state_in = S_READ;
               tried_in = tried_ff + IW'(1);
               probe_in = (probe_ff == LAST) ? '0 : probe_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      tried_ff <= tried_in;
      item_ff  <= item_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= table_mem[probe_ff];
   end

endmodule

FILE: rtl/dest_ip_packet_steering.sv
`timescale 1ns / 1ps
// channel    ports                       beat
// request    req_push, req_full          req_data  (req_type)
// response   rsp_pop, rsp_empty          rsp_data  (rsp_type)
//
// A request beat lands in a two-entry queue after classification. Drops are
// answered from the idle state with no table access; a lookup or insert probes
// the table one slot at a time (registered memory read, then compare), with
// linear probing from the hashed home slot, visiting at most TABLE_ENTRIES
// slots. After reset the table is swept clear, one slot after another;
// requests queue up meanwhile but are not served. A held response stalls the
// back end only; the queue keeps taking beats until it fills.
module dest_ip_packet_steering
   import dip_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int CLIENT_LIMIT  = CLIENT_LIMIT_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   work_type work, q_data;
   logic     q_empty, q_pop;

   dip_front u_front (
      .req  (req_data),
      .work (work)
   );

   dip_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (work),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   dip_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CLIENT_LIMIT  (CLIENT_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_forward_in_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_FORWARD) |->
         ({4'd0, rsp_data.client} < 11'(CLIENT_LIMIT)))
      else $error("forwarded client out of range");

   a_drop_client_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_FORWARD) |-> (rsp_data.client == 7'd0))
      else $error("client set on a non-forward response");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_empty && (rsp_empty || rsp_pop)))
      else $error("queue popped without room for the response");

endmodule
